@@ rtl/fractal_value_noise_core_defines.svh @@
// assertion macros for the fractal value noise core
// no dependencies; taken in by the files that carry assertions
`ifndef FRACTAL_VALUE_NOISE_CORE_DEFINES_SVH
`define FRACTAL_VALUE_NOISE_CORE_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define FVN_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define FVN_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/fvn_pkg.sv @@
// shared types, codes and the quintic fade rom for the fractal value noise core
// no dependencies
package fvn_pkg;

    localparam int SUM_W     = 20;
    localparam int CFG_IDX_W = 2;

    localparam logic [1:0] MODE_PERM   = 2'd0;
    localparam logic [1:0] MODE_WEIGHT = 2'd1;
    localparam logic [1:0] MODE_EVAL   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_OCTAVE_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_LOG2  = 2'd1;

    localparam logic [3:0] OCTAVE_COUNT_RESET = 4'd1;
    localparam logic [3:0] PERIOD_LOG2_RESET  = 4'd8;
    localparam logic [8:0] WEIGHT_FIRST       = 9'd256;

    typedef enum logic [2:0] {
        S_IDLE,
        S_HASH,
        S_ROW0,
        S_ROW1,
        S_DRAIN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic wt_load;
        logic step;
    } t_cell_ctl;

    typedef logic [7:0] t_fade_rom [256];

    // entry i = round(255 * (6t^5 - 15t^4 + 10t^3)), t = i/256, exact integer form
    function automatic t_fade_rom fade_rom_init();
        t_fade_rom       rom;
        longint unsigned k;
        longint unsigned i3;
        longint unsigned num;
        for (int i = 0; i < 256; i++) begin
            k   = 64'(i);
            i3  = k * k * k;
            num = 64'd6 * i3 * k * k + 64'd655360 * i3 - 64'd3840 * i3 * k;
            rom[i] = 8'((64'd255 * num + (64'd1 << 39)) >> 40);
        end
        return rom;
    endfunction

    localparam t_fade_rom FADE = fade_rom_init();

endpackage

@@ rtl/fvn_perm_ram.sv @@
// 256 x 8 permutation memory, one write port and two registered read ports
// no dependencies
module fvn_perm_ram (
    input  logic       i_clk,
    input  logic       i_we,
    input  logic [7:0] i_waddr,
    input  logic [7:0] i_wdata,
    input  logic [7:0] i_raddr_a,
    input  logic [7:0] i_raddr_b,
    output logic [7:0] o_rdata_a,
    output logic [7:0] o_rdata_b
);

    logic [7:0] r_mem [256];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

@@ rtl/fvn_octave_cell.sv @@
// one octave cell: holds its weight, adds weight * octave value to the
// partial sum handed on by the previous cell; uses fvn_pkg
module fvn_octave_cell (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  fvn_pkg::t_cell_ctl          i_ctl,
    input  logic [8:0]                  i_wt_init,
    input  logic [8:0]                  i_wt_value,
    input  logic [7:0]                  i_value,
    input  logic [fvn_pkg::SUM_W-1:0]   i_sum,
    output logic [fvn_pkg::SUM_W-1:0]   o_sum
);
    import fvn_pkg::*;

    logic [8:0]       r_weight;
    logic [SUM_W-1:0] r_sum;
    logic [SUM_W-1:0] n_sum;
    logic [16:0]      w_prod;

    assign w_prod = r_weight * i_value;
    assign n_sum  = i_sum + SUM_W'(w_prod);
    assign o_sum  = r_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weight <= i_wt_init;
        end else if (i_ctl.wt_load) begin
            r_weight <= i_wt_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.step) begin
            r_sum <= n_sum;
        end
    end

endmodule

@@ rtl/fractal_value_noise_core.sv @@
// fractal value noise core: octave sequencer, two-port perm memory, blend stages, octave cells
// depends on fvn_pkg, fvn_perm_ram, fvn_octave_cell and the assertion macro header
// load items are taken whenever the core is idle; after an evaluate item is accepted the input
// stays stalled until its result is loaded into the output register, the octave walk doing
// three read pairs per octave on the shared permutation memory
// synchronous active-low reset; perm memory undefined until written, weights 256,0,..
`include "fractal_value_noise_core_defines.svh"
module fractal_value_noise_core #(
    parameter int OCT_SLOTS = 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [fvn_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [3:0]                       i_cfg_data,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [1:0]                       i_mode,
    input  logic [7:0]                       i_table_index,
    input  logic [8:0]                       i_table_value,
    input  logic signed [31:0]               i_x_pos,
    input  logic signed [31:0]               i_y_pos,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [7:0]                       o_noise_value
);
    import fvn_pkg::*;

    localparam int OCT_W = (OCT_SLOTS > 1) ? $clog2(OCT_SLOTS) : 1;

    t_state           r_state;
    t_state           n_state;
    logic [3:0]       r_octave_count;
    logic [3:0]       r_period_log2;
    logic [31:0]      r_x;
    logic [31:0]      r_y;
    logic [OCT_W-1:0] r_oct;
    logic [OCT_W-1:0] r_oct_last;
    logic [3:0]       r_pl;
    logic [7:0]       r_cy0;
    logic [7:0]       r_cy1;
    logic [7:0]       r_fx;
    logic [7:0]       r_fy;
    logic [7:0]       r_h1;
    logic [7:0]       r_v00;
    logic [7:0]       r_v01;
    logic             r_b1_vld;
    logic [OCT_W-1:0] r_b1_oct;
    logic             r_b2_vld;
    logic [OCT_W-1:0] r_b2_oct;
    logic [7:0]       r_b2_fx;
    logic [7:0]       r_left;
    logic [7:0]       r_right;
    logic             r_val_vld;
    logic [OCT_W-1:0] r_val_oct;
    logic [7:0]       r_val;
    logic             r_out_vld;
    logic [7:0]       r_out_data;

    logic             w_in_acc;
    logic             w_eval_acc;
    logic             w_out_load;
    logic [3:0]       w_oc_clamp;
    logic [3:0]       w_pl_limit;
    logic [3:0]       w_pl_clamp;
    logic [31:0]      w_xs;
    logic [31:0]      w_ys;
    logic [3:0]       w_wrap_log2;
    logic [7:0]       w_wrap;
    logic [7:0]       w_cx0;
    logic [7:0]       w_cx1;
    logic [7:0]       w_cy0;
    logic [7:0]       w_cy1;
    logic [7:0]       w_rd_a;
    logic [7:0]       w_rd_b;
    logic [7:0]       w_ram_a;
    logic [7:0]       w_ram_b;
    logic [SUM_W-1:0] w_cell_sum [OCT_SLOTS];
    logic [SUM_W-1:0] w_final;
    logic [SUM_W-9:0] w_scaled;
    logic [7:0]       w_result;

    // a + floor((b - a) * t / 256)
    function automatic logic [7:0] lerp8(input logic [7:0] a, input logic [7:0] b,
                                         input logic [7:0] t);
        logic signed [8:0]  d;
        logic signed [17:0] p;
        logic signed [9:0]  q;
        logic signed [9:0]  s;
        d = $signed({1'b0, b}) - $signed({1'b0, a});
        p = d * $signed({1'b0, t});
        q = $signed(p[17:8]);
        s = $signed({2'b00, a}) + q;
        return s[7:0];
    endfunction

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != S_IDLE);
    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign w_eval_acc  = w_in_acc && (i_mode == MODE_EVAL);

    // octave count and period clamps
    always_comb begin
        if (r_octave_count == 4'd0) begin
            w_oc_clamp = 4'd1;
        end else if (r_octave_count > 4'(OCT_SLOTS)) begin
            w_oc_clamp = 4'(OCT_SLOTS);
        end else begin
            w_oc_clamp = r_octave_count;
        end
        w_pl_limit = 4'd9 - w_oc_clamp;
        w_pl_clamp = (r_period_log2 > w_pl_limit) ? w_pl_limit : r_period_log2;
    end

    // cell coordinates of the current octave
    assign w_xs        = r_x << r_oct;
    assign w_ys        = r_y << r_oct;
    assign w_wrap_log2 = r_pl + 4'(r_oct);
    assign w_wrap      = 8'((9'd1 << w_wrap_log2) - 9'd1);
    assign w_cx0       = w_xs[23:16] & w_wrap;
    assign w_cx1       = (w_cx0 + 8'd1) & w_wrap;
    assign w_cy0       = w_ys[23:16] & w_wrap;
    assign w_cy1       = (w_cy0 + 8'd1) & w_wrap;

    always_comb begin
        n_state    = r_state;
        w_rd_a     = w_cx0;
        w_rd_b     = w_cx1;
        w_out_load = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (w_eval_acc) begin
                    n_state = S_HASH;
                end
            end
            S_HASH: begin
                n_state = S_ROW0;
            end
            S_ROW0: begin
                // ram holds h0 and h1
                w_rd_a  = w_ram_a + r_cy0;
                w_rd_b  = w_ram_a + r_cy1;
                n_state = S_ROW1;
            end
            S_ROW1: begin
                w_rd_a  = r_h1 + r_cy0;
                w_rd_b  = r_h1 + r_cy1;
                n_state = (r_oct == r_oct_last) ? S_DRAIN : S_HASH;
            end
            S_DRAIN: begin
                if (r_val_vld && (r_val_oct == r_oct_last)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_vld || !i_out_stall) begin
                    w_out_load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_oct     <= '0;
            r_b1_vld  <= 1'b0;
            r_b2_vld  <= 1'b0;
            r_val_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_b1_vld  <= (r_state == S_ROW1);
            r_b2_vld  <= r_b1_vld;
            r_val_vld <= r_b2_vld;
            if (w_eval_acc) begin
                r_oct <= '0;
            end else if (r_state == S_ROW1 && r_oct != r_oct_last) begin
                r_oct <= r_oct + 1'b1;
            end
            if (w_out_load) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_octave_count <= OCTAVE_COUNT_RESET;
            r_period_log2  <= PERIOD_LOG2_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == CFG_OCTAVE_COUNT) begin
                r_octave_count <= i_cfg_data;
            end else if (i_cfg_index == CFG_PERIOD_LOG2) begin
                r_period_log2 <= i_cfg_data;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (w_eval_acc) begin
            r_x        <= i_x_pos;
            r_y        <= i_y_pos;
            r_oct_last <= OCT_W'(w_oc_clamp - 4'd1);
            r_pl       <= w_pl_clamp;
        end
        if (r_state == S_HASH) begin
            r_cy0 <= w_cy0;
            r_cy1 <= w_cy1;
            r_fx  <= FADE[w_xs[15:8]];
            r_fy  <= FADE[w_ys[15:8]];
        end
        if (r_state == S_ROW0) begin
            r_h1 <= w_ram_b;
        end
        if (r_state == S_ROW1) begin
            r_v00    <= w_ram_a;
            r_v01    <= w_ram_b;
            r_b1_oct <= r_oct;
        end
        // ram now holds v10 and v11; r_fy still belongs to this octave
        if (r_b1_vld) begin
            r_left   <= lerp8(r_v00, r_v01, r_fy);
            r_right  <= lerp8(w_ram_a, w_ram_b, r_fy);
            r_b2_fx  <= r_fx;
            r_b2_oct <= r_b1_oct;
        end
        if (r_b2_vld) begin
            r_val     <= lerp8(r_left, r_right, r_b2_fx);
            r_val_oct <= r_b2_oct;
        end
        if (w_out_load) begin
            r_out_data <= w_result;
        end
    end

    fvn_perm_ram u_perm_ram (
        .i_clk     (i_clk),
        .i_we      (w_in_acc && (i_mode == MODE_PERM)),
        .i_waddr   (i_table_index),
        .i_wdata   (i_table_value[7:0]),
        .i_raddr_a (w_rd_a),
        .i_raddr_b (w_rd_b),
        .o_rdata_a (w_ram_a),
        .o_rdata_b (w_ram_b)
    );

    for (genvar g = 0; g < OCT_SLOTS; g++) begin : g_cell
        t_cell_ctl        w_ctl;
        logic [SUM_W-1:0] w_sum_in;

        assign w_ctl.wt_load = w_in_acc && (i_mode == MODE_WEIGHT)
                               && (i_table_index == 8'(g));
        assign w_ctl.step    = r_val_vld && (r_val_oct == OCT_W'(g));
        if (g == 0) begin : g_head
            assign w_sum_in = '0;
        end else begin : g_link
            assign w_sum_in = w_cell_sum[g-1];
        end

        fvn_octave_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (w_ctl),
            .i_wt_init  ((g == 0) ? WEIGHT_FIRST : 9'd0),
            .i_wt_value (i_table_value),
            .i_value    (r_val),
            .i_sum      (w_sum_in),
            .o_sum      (w_cell_sum[g])
        );
    end

    // sum >> 8, saturated
    assign w_final  = w_cell_sum[r_oct_last];
    assign w_scaled = w_final[SUM_W-1:8];
    assign w_result = (|w_scaled[SUM_W-9:8]) ? 8'hFF : w_scaled[7:0];

    assign o_out_valid   = r_out_vld;
    assign o_noise_value = r_out_data;

    `FVN_ASSERT_NXT(a_eval_starts, i_clk, i_rst_n, w_eval_acc, r_state == S_HASH, "eval item did not start the octave walk")
    `FVN_ASSERT_IMP(a_last_in_drain, i_clk, i_rst_n, r_val_vld && (r_val_oct == r_oct_last), r_state == S_DRAIN, "last octave value outside drain")
    `FVN_ASSERT_IMP(a_oct_bound, i_clk, i_rst_n, r_state != S_IDLE, r_oct <= r_oct_last, "octave counter past the last octave")
    `FVN_ASSERT_IMP(a_out_from_done, i_clk, i_rst_n, $rose(o_out_valid), $past(r_state) == S_DONE, "result loaded outside done")

endmodule

@@ dv/fvn_noise_checker.sv @@
// checker for the fractal value noise core: watches the config, item and result channels,
// predicts each noise value from its own copy of the tables and compares in order
// depends on fvn_pkg for the mode and register codes
module fvn_noise_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    input  logic                          i_cfg_ready,
    input  logic [fvn_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [3:0]                    i_cfg_data,
    input  logic                          i_in_valid,
    input  logic                          i_in_stall,
    input  logic [1:0]                    i_mode,
    input  logic [7:0]                    i_table_index,
    input  logic [8:0]                    i_table_value,
    input  logic [31:0]                   i_x_pos,
    input  logic [31:0]                   i_y_pos,
    input  logic                          i_out_valid,
    input  logic                          i_out_stall,
    input  logic [7:0]                    i_noise_value,
    output int                            o_fail_count,
    output int                            o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import fvn_pkg::*;

    localparam int NUM_OCTAVES = 8;

    logic [7:0] perm_copy [256];
    logic [8:0] weight_copy [NUM_OCTAVES];
    logic [7:0] fade_ref [256];
    logic [3:0] octaves_reg;
    logic [3:0] period_reg;
    logic [7:0] noise_due [$];
    int         errors;

    // quintic fade, exact integer form: 255 * i^3 * (6i^2 - 3840i + 655360) over 2^40, rounded
    initial begin
        longint unsigned k;
        longint unsigned cube;
        for (int i = 0; i < 256; i++) begin
            k    = longint'(i);
            cube = k * k * k;
            fade_ref[i] = 8'((64'd255 * cube * (64'd6 * k * k + 64'd655360 - 64'd3840 * k)
                              + (64'd1 << 39)) >> 40);
        end
        for (int i = 0; i < 256; i++)
            perm_copy[i] = 8'd0;
    end

    // arithmetic shift gives the round toward minus infinity
    function automatic int blend(input int a, input int b, input int t);
        int d;
        d = (b - a) * t;
        return a + (d >>> 8);
    endfunction

    function automatic logic [7:0] noise_at(input logic [31:0] x, input logic [31:0] y);
        int          oct_n;
        int          per;
        int          wrap;
        int          cx0, cx1, cy0, cy1;
        int          h0, h1;
        int          v00, v01, v10, v11;
        int          fx, fy;
        logic [31:0] xs, ys;
        logic [31:0] acc;
        oct_n = int'(octaves_reg);
        if (oct_n < 1) oct_n = 1;
        if (oct_n > NUM_OCTAVES) oct_n = NUM_OCTAVES;
        per = int'(period_reg);
        if (per > 9 - oct_n) per = 9 - oct_n;
        acc = '0;
        for (int o = 0; o < oct_n; o++) begin
            xs   = x << o;
            ys   = y << o;
            wrap = (1 << (per + o)) - 1;
            cx0  = int'(xs[31:16]) & wrap;
            cy0  = int'(ys[31:16]) & wrap;
            cx1  = (cx0 + 1) & wrap;
            cy1  = (cy0 + 1) & wrap;
            h0   = perm_copy[cx0 & 255];
            h1   = perm_copy[cx1 & 255];
            v00  = perm_copy[(h0 + cy0) & 255];
            v01  = perm_copy[(h0 + cy1) & 255];
            v10  = perm_copy[(h1 + cy0) & 255];
            v11  = perm_copy[(h1 + cy1) & 255];
            fx   = fade_ref[xs[15:8]];
            fy   = fade_ref[ys[15:8]];
            acc  = acc + 32'(weight_copy[o]) * 32'(blend(blend(v00, v01, fy),
                                                         blend(v10, v11, fy), fx));
        end
        acc = acc >> 8;
        return (acc > 32'd255) ? 8'd255 : acc[7:0];
    endfunction

    always @(posedge i_clk) begin
        logic [7:0] want;
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_OCTAVES; i++)
                weight_copy[i] = 9'd0;
            weight_copy[0] = 9'd256;
            octaves_reg    = 4'd1;
            period_reg     = 4'd8;
            noise_due.delete();
            errors         = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_OCTAVE_COUNT: octaves_reg = i_cfg_data;
                    CFG_PERIOD_LOG2:  period_reg  = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                case (i_mode)
                    MODE_PERM: perm_copy[i_table_index] = i_table_value[7:0];
                    MODE_WEIGHT: begin
                        if (i_table_index < NUM_OCTAVES)
                            weight_copy[i_table_index[2:0]] = i_table_value;
                    end
                    MODE_EVAL: noise_due.push_back(noise_at(i_x_pos, i_y_pos));
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (noise_due.size() == 0) begin
                    $error("noise_value: expected none, got %0d", i_noise_value);
                    errors++;
                end else begin
                    want = noise_due.pop_front();
                    if (i_noise_value !== want) begin
                        $error("noise_value: expected %0d, got %0d", want, i_noise_value);
                        errors++;
                    end
                end
            end
        end
        o_pending    <= noise_due.size();
        o_fail_count <= errors;
    end

endmodule

@@ dv/tb_fractal_value_noise_core.sv @@
// testbench top for the fractal value noise core: reset, config phases, directed and
// random items with random idling on both channels; depends on fvn_pkg and fvn_noise_checker
module tb_fractal_value_noise_core;
    timeunit 1ns;
    timeprecision 1ps;
    import fvn_pkg::*;

    localparam logic [1:0]           MODE_SPARE   = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE    = 2'd3;
    localparam int                   SETTLE       = 40;
    localparam int                   CYCLE_LIMIT  = 400000;
    localparam int                   PHASE_ITEMS  = 95;
    localparam int                   NUM_PHASES   = 10;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [3:0]           cfg_data;
    logic                 in_valid;
    logic                 in_stall;
    logic [1:0]           in_mode;
    logic [7:0]           in_index;
    logic [8:0]           in_value;
    logic [31:0]          x_pos;
    logic [31:0]          y_pos;
    logic                 out_valid;
    logic                 out_stall;
    logic [7:0]           noise_value;
    int                   fail_count;
    int                   pending;
    int                   cycles = 0;
    bit                   calm = 1'b0;

    fractal_value_noise_core dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_mode        (in_mode),
        .i_table_index (in_index),
        .i_table_value (in_value),
        .i_x_pos       (x_pos),
        .i_y_pos       (y_pos),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_noise_value (noise_value)
    );

    fvn_noise_checker checker_i (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_valid   (cfg_valid),
        .i_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_mode        (in_mode),
        .i_table_index (in_index),
        .i_table_value (in_value),
        .i_x_pos       (x_pos),
        .i_y_pos       (y_pos),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_noise_value (noise_value),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("tb_fractal_value_noise_core: done, errors");
            $finish;
        end
    end

    // result side: a random stall before each result, none in calm stretches
    initial begin
        int hold;
        out_stall <= 1'b0;
        forever begin
            hold = calm ? 0 : $urandom_range(0, 8);
            if (hold > 0) begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
                out_stall <= 1'b0;
            end
            do @(posedge clk); while (!out_valid);
        end
    end

    task automatic push_item(input logic [1:0] mode, input logic [7:0] idx,
                             input logic [8:0] val, input logic [31:0] x,
                             input logic [31:0] y);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_mode  <= mode;
        in_index <= idx;
        in_value <= val;
        x_pos    <= x;
        y_pos    <= y;
        do @(posedge clk); while (in_stall);
    endtask

    // registers change only once every result is out and loads have settled
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [3:0] data);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic push_eval(input logic [31:0] x, input logic [31:0] y);
        push_item(MODE_EVAL, 8'($urandom), 9'($urandom), x, y);
    endtask

    task automatic push_random_item();
        int          pick;
        logic [7:0]  idx;
        logic [8:0]  val;
        pick = $urandom_range(0, 99);
        if (pick < 78) begin
            push_eval($urandom, $urandom);
        end else if (pick < 86) begin
            push_item(MODE_PERM, 8'($urandom), 9'($urandom), $urandom, $urandom);
        end else if (pick < 94) begin
            idx = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, 7)) : 8'($urandom);
            case ($urandom_range(0, 9))
                0:       val = 9'($urandom);
                1, 2, 3: val = 9'($urandom_range(0, 256));
                default: val = 9'($urandom_range(0, 96));
            endcase
            push_item(MODE_WEIGHT, idx, val, $urandom, $urandom);
        end else begin
            push_item(MODE_SPARE, 8'($urandom), 9'($urandom), $urandom, $urandom);
        end
    endtask

    initial begin
        logic [3:0] oct_set  [NUM_PHASES];
        logic [3:0] per_set  [NUM_PHASES];
        int         oct_eff;
        rst_n     <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        in_valid  <= 1'b0;
        in_mode   <= MODE_PERM;
        in_index  <= '0;
        in_value  <= '0;
        x_pos     <= '0;
        y_pos     <= '0;
        oct_set = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd8, 4'd4, 4'd2, 4'd3, 4'd6, 4'($urandom)};
        per_set = '{4'd8, 4'd0, 4'd15, 4'd15, 4'd1, 4'd3, 4'd7, 4'd2, 4'd15, 4'($urandom)};
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // whole permutation table first, values with the ninth bit set now and then
        for (int i = 0; i < 256; i++)
            push_item(MODE_PERM, 8'(i), 9'($urandom), $urandom, $urandom);

        // directed: position extremes, wrap at the last cell, odd loads, ignored items
        push_eval(32'h0000_0000, 32'h0000_0000);
        push_eval(32'h7fff_ffff, 32'h8000_0000);
        push_eval(32'h8000_0000, 32'h7fff_ffff);
        push_eval(32'hffff_ffff, 32'hffff_ffff);
        push_eval(32'h0000_ff00, 32'h00ff_00ff);
        push_item(MODE_PERM, 8'd255, 9'd256, 32'hffff_ffff, 32'h0);
        push_item(MODE_PERM, 8'd0, 9'd255, 32'h0, 32'hffff_ffff);
        push_eval(32'h00ff_8000, 32'h00ff_c000);
        push_item(MODE_WEIGHT, 8'd0, 9'd511, 32'h0, 32'h0);
        push_eval($urandom, $urandom);
        push_eval($urandom, $urandom);
        push_eval($urandom, $urandom);
        push_item(MODE_WEIGHT, 8'd8, 9'd300, 32'h0, 32'h0);
        push_item(MODE_WEIGHT, 8'd255, 9'd1, 32'h0, 32'h0);
        push_item(MODE_SPARE, 8'hff, 9'h1ff, 32'hffff_ffff, 32'hffff_ffff);
        push_item(MODE_WEIGHT, 8'd0, 9'd0, 32'h0, 32'h0);
        push_eval($urandom, $urandom);
        push_item(MODE_WEIGHT, 8'd0, 9'd256, 32'h0, 32'h0);
        push_eval($urandom, $urandom);
        push_eval(32'h0001_0000, 32'hffff_0000);

        for (int p = 0; p < NUM_PHASES; p++) begin
            write_reg(CFG_OCTAVE_COUNT, oct_set[p]);
            write_reg(CFG_PERIOD_LOG2, per_set[p]);
            if (p == 5)
                write_reg(CFG_SPARE, 4'($urandom));
            oct_eff = (oct_set[p] == 0) ? 1 : (oct_set[p] > 8) ? 8 : int'(oct_set[p]);
            // spread the weight over the active octaves so the sum mostly stays in range
            for (int o = 0; o < 8; o++)
                push_item(MODE_WEIGHT, 8'(o), 9'($urandom_range(0, 320 / oct_eff)),
                          $urandom, $urandom);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n % 40 == 0)
                    calm = ($urandom_range(0, 3) == 0);
                push_random_item();
            end
            calm = 1'b0;
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (fail_count == 0)
            $display("tb_fractal_value_noise_core: done, clean");
        else
            $display("tb_fractal_value_noise_core: done, errors");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/fvn_pkg.sv
rtl/fvn_perm_ram.sv
rtl/fvn_octave_cell.sv
rtl/fractal_value_noise_core.sv
dv/fvn_noise_checker.sv
dv/tb_fractal_value_noise_core.sv
